FILE: rtl/scbp_pkg.sv
package scbp_pkg;

  localparam int WordW   = 32;
  localparam int LimitW  = 33;
  localparam int KeyWords   = 4;
  localparam int RoundWords = 10;
  localparam int RkIdxW  = $clog2(RoundWords);
  localparam int RcIdxW  = $clog2(RoundWords - KeyWords);
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_ZERO  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_ONE   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_TWO   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_THREE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RANGE_LIMIT    = 3'd4;

  localparam logic [LimitW-1:0] LIMIT_RESET = {1'b1, {WordW{1'b0}}};

  typedef enum logic [1:0] {
    ST_EXPAND,
    ST_IDLE,
    ST_ENC,
    ST_WAIT
  } state_t;

  localparam logic [WordW-1:0] ROUND_CONST [RoundWords-KeyWords] = '{
    32'h01010000, 32'h04040202, 32'h10100808,
    32'h40402020, 32'h1B1B8080, 32'h6C6C3636
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

endpackage

FILE: rtl/scbp_round.sv
module scbp_round (
  input  logic [scbp_pkg::WordW-1:0] din,
  input  logic                       mix,
  output logic [scbp_pkg::WordW-1:0] dout
);
  import scbp_pkg::*;

  logic [7:0] sb [4];
  logic [31:0] rw;
  logic [31:0] rot;
  logic [3:0] hi [4];
  logic [3:0] lo [4];
  logic [3:0] hi_o [4];
  logic [3:0] lo_o [4];
  logic [3:0] th, tl;
  logic [3:0] dh, dl;
  logic [31:0] mixed;

  always_comb begin
    for (int k = 0; k < 4; k++) sb[k] = SBOX[din[8*k +: 8]];
    rw  = {{sb[3][1:0], sb[3][7:2]}, {sb[2][3:0], sb[2][7:4]},
           {sb[1][5:0], sb[1][7:6]}, sb[0]};
    rot = {rw[27:0], rw[31:28]};
    for (int k = 0; k < 4; k++) begin
      hi[k] = rot[8*k+4 +: 4];
      lo[k] = rot[8*k +: 4];
    end
    th = hi[0] ^ hi[1] ^ hi[2] ^ hi[3];
    tl = lo[0] ^ lo[1] ^ lo[2] ^ lo[3];
    for (int k = 0; k < 4; k++) begin
      // truncated doubling of the neighbor difference
      dh = hi[k] ^ hi[(k + 1) % 4];
      dl = lo[k] ^ lo[(k + 1) % 4];
      hi_o[k] = hi[k] ^ th ^ {dh[2:0], 1'b0};
      lo_o[k] = lo[k] ^ tl ^ {dl[2:0], 1'b0};
    end
    for (int k = 0; k < 4; k++) mixed[8*k +: 8] = {hi_o[k], lo_o[k]};
    dout = mix ? mixed : rot;
  end

endmodule

FILE: rtl/small_block_cipher_permutation.sv
// after the input transfer, nine rounds run and the result is then loaded to m_tvalid,
// and each extra cycle-walking pass adds nine more rounds when the limit is below 2^32
// a new item is taken only after the last one has left ST_WAIT; one shared round unit
// does one round per cycle, for both key expansion and encryption
// reset: synchronous; keys clear, limit goes to 2^32, then key expansion runs
// (also after every key write) with s_tready low
module small_block_cipher_permutation (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // [31:0] plain_index
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,   // [31:0] permuted_value
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [scbp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [scbp_pkg::LimitW-1:0]   cfg_data
);
  import scbp_pkg::*;

  state_t state, state_next;
  logic [WordW-1:0]  rk [RoundWords];
  logic [LimitW-1:0] limit;
  logic [WordW-1:0]  w, w_next;
  logic [WordW-1:0]  start;
  logic [RkIdxW-1:0] ki, ki_next;
  logic [RkIdxW-1:0] kj, kj_next;
  logic              rk_we;
  logic [WordW-1:0]  round_in, round_out, step_out;
  logic              round_mix;
  logic              out_load;
  logic              cfg_fire, key_write;
  logic              walk_done;

  // config only between items, and it wins over a new input
  assign cfg_ready = (state == ST_IDLE) || (state == ST_EXPAND);
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign key_write = cfg_fire && (cfg_index == REG_KEY_WORD_ZERO ||
                     cfg_index == REG_KEY_WORD_ONE || cfg_index == REG_KEY_WORD_TWO ||
                     cfg_index == REG_KEY_WORD_THREE);

  assign s_tready  = (state == ST_IDLE) && !cfg_valid;
  assign round_in  = (state == ST_EXPAND) ? (w ^ rk[kj]) : w;
  assign round_mix = (state == ST_EXPAND) || (kj != RkIdxW'(RoundWords - 1));

  scbp_round u_round (
    .din  (round_in),
    .mix  (round_mix),
    .dout (round_out)
  );

  assign step_out  = round_out ^ rk[kj];
  assign walk_done = ({1'b0, step_out} < limit) || (step_out == start);

  always_comb begin
    state_next = state;
    w_next     = w;
    ki_next    = ki;
    kj_next    = kj;
    rk_we      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_EXPAND: begin
        w_next = round_out;
        if (kj == ki - RkIdxW'(1)) begin
          rk_we = 1'b1;
          if (ki == RkIdxW'(RoundWords - 1)) begin
            state_next = ST_IDLE;
          end else begin
            ki_next = ki + RkIdxW'(1);
            kj_next = '0;
            w_next  = ROUND_CONST[RcIdxW'(ki - RkIdxW'(KeyWords - 1))];
          end
        end else begin
          kj_next = kj + RkIdxW'(1);
        end
      end
      ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          state_next = ST_ENC;
          w_next     = s_tdata ^ rk[0];
          kj_next    = RkIdxW'(1);
        end
      end
      ST_ENC: begin
        w_next = step_out;
        if (kj == RkIdxW'(RoundWords - 1)) begin
          if (walk_done) begin
            state_next = ST_WAIT;
          end else begin
            // walk again on the encrypted value
            w_next  = step_out ^ rk[0];
            kj_next = RkIdxW'(1);
          end
        end else begin
          kj_next = kj + RkIdxW'(1);
        end
      end
      ST_WAIT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    // key change restarts expansion
    if (key_write) begin
      state_next = ST_EXPAND;
      ki_next    = RkIdxW'(KeyWords);
      kj_next    = '0;
      w_next     = ROUND_CONST[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EXPAND;
      ki    <= RkIdxW'(KeyWords);
      kj    <= '0;
      w     <= ROUND_CONST[0];
      limit <= LIMIT_RESET;
      for (int k = 0; k < KeyWords; k++) rk[k] <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      ki    <= ki_next;
      kj    <= kj_next;
      w     <= w_next;
      if (cfg_fire) begin
        if (cfg_index == REG_RANGE_LIMIT) limit <= cfg_data;
        else if (key_write) rk[RkIdxW'(cfg_index[1:0])] <= cfg_data[WordW-1:0];
      end
      if (rk_we) rk[ki] <= round_out;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid && s_tready) start <= s_tdata;
    if (out_load) m_tdata <= w;
  end

endmodule
